// ===== hw/rtl/mvm_pkg.sv =====
// Shared types and constants of the matrix-vector multiply block.
`default_nettype none

package mvm_pkg;

    // Default store dimension and the hard limit on result rows per run
    localparam int MAX_SIZE_DEF = 16;
    localparam int OUT_LIMIT    = 16;

    // Field widths
    localparam int VAL_W   = 16;   // Q8.8 element
    localparam int MUL_W   = 32;   // Q16.16 single product
    localparam int PROD_W  = 40;   // Q24.16 result
    localparam int IDX_IN_W = 4;   // row / col fields
    localparam int SIZE_W  = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Register index decoded from the word address
    localparam logic REG_SIZE = 1'b0;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        ACT_MAT_WR  = 2'd0,
        ACT_VEC_WR  = 2'd1,
        ACT_COMPUTE = 2'd2
    } t_action;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Tag that travels with each element-pair read into the MAC pipe
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_issue;

    // Request to load a finished row sum into the output register
    typedef struct packed {
        logic                load;
        logic [IDX_IN_W-1:0] row;
        logic                last;
    } t_emit;

endpackage

`default_nettype wire

// ===== hw/rtl/mvm_store.sv =====
// Matrix and vector element memories with registered read ports.
`default_nettype none

module mvm_store
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_mat_we,
    input  wire logic [2*((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] i_mat_waddr,
    input  wire logic                 i_vec_we,
    input  wire logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]   i_vec_waddr,
    input  wire logic [VAL_W-1:0]     i_wdata,
    input  wire logic [2*((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] i_mat_raddr,
    input  wire logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]   i_vec_raddr,
    output logic      [VAL_W-1:0]     o_mat_rdata,
    output logic      [VAL_W-1:0]     o_vec_rdata
);

    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [VAL_W-1:0] r_mat_mem [2**(2*IDX_W)];
    logic [VAL_W-1:0] r_vec_mem [2**IDX_W];

    // Matrix memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_mat_we) begin
            r_mat_mem[i_mat_waddr] <= i_wdata;
        end
        o_mat_rdata <= r_mat_mem[i_mat_raddr];
    end

    // Vector memory
    always_ff @(posedge i_clk) begin
        if (i_vec_we) begin
            r_vec_mem[i_vec_waddr] <= i_wdata;
        end
        o_vec_rdata <= r_vec_mem[i_vec_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mvm_mac.sv =====
// Shared multiply-accumulate unit: registered multiply, then running sum.
`default_nettype none

module mvm_mac
    import mvm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_issue            i_issue,
    input  wire logic [VAL_W-1:0]  i_mat_data,
    input  wire logic [VAL_W-1:0]  i_vec_data,
    output logic      [PROD_W-1:0] o_acc,
    output logic                   o_done
);

    t_issue                    r_tag_rd;
    t_issue                    r_tag_mul;
    logic signed [MUL_W-1:0]   r_mul;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  mul_ext;
    logic                      r_done;

    // Tags: align with the memory read, then with the multiply register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_rd  <= '0;
            r_tag_mul <= '0;
            r_done    <= 1'b0;
        end else begin
            r_tag_rd  <= i_issue;
            r_tag_mul <= r_tag_rd;
            r_done    <= r_tag_mul.valid & r_tag_mul.last;
        end
    end

    // Q8.8 x Q8.8 -> Q16.16, exact
    always_ff @(posedge i_clk) begin
        r_mul <= $signed(i_mat_data) * $signed(i_vec_data);
    end

    assign mul_ext = {{(PROD_W-MUL_W){r_mul[MUL_W-1]}}, r_mul};

    // Running sum; at most OUT_LIMIT terms, so 40 bits never overflow
    always_ff @(posedge i_clk) begin
        if (r_tag_mul.valid) begin
            r_acc <= r_tag_mul.first ? mul_ext : r_acc + mul_ext;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== hw/rtl/mvm_ctrl.sv =====
// Sequencer: walks rows and columns through the shared MAC and hands out sums.
`default_nettype none

module mvm_ctrl
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire t_action             i_action,
    input  wire logic [SIZE_W-1:0]   i_size,
    input  wire logic                i_acc_done,
    input  wire logic                i_out_free,
    output logic                     o_in_ready,
    output t_issue                   o_issue,
    output logic [IDX_IN_W-1:0]      o_rd_row,
    output logic [IDX_IN_W-1:0]      o_rd_col,
    output t_emit                    o_emit
);

    localparam int N_LIM = (MAX_SIZE < OUT_LIMIT) ? MAX_SIZE : OUT_LIMIT;

    t_state              r_state, n_state;
    logic [IDX_IN_W-1:0] r_row, n_row;
    logic [IDX_IN_W-1:0] r_col, n_col;
    logic [SIZE_W-1:0]   r_n, n_n;
    logic [SIZE_W-1:0]   size_eff;
    logic [SIZE_W-1:0]   last_idx;
    logic                start;
    logic                col_last;
    logic                row_last;

    // Clamp the configured size to 1 .. N_LIM
    always_comb begin
        if (i_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (32'(i_size) > N_LIM) begin
            size_eff = SIZE_W'(N_LIM);
        end else begin
            size_eff = i_size;
        end
    end

    assign last_idx = r_n - SIZE_W'(1);
    assign start    = i_in_valid && (i_action == ACT_COMPUTE);
    assign col_last = (SIZE_W'(r_col) == last_idx);
    assign row_last = (SIZE_W'(r_row) == last_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start)      n_state = S_ISSUE;
            S_ISSUE: if (col_last)   n_state = S_DRAIN;
            S_DRAIN: if (i_acc_done) n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = row_last ? S_IDLE : S_ISSUE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and counter updates
    always_comb begin
        o_in_ready   = 1'b0;
        o_issue      = '0;
        o_emit       = '0;
        o_emit.row   = r_row;
        o_emit.last  = row_last;
        n_row        = r_row;
        n_col        = r_col;
        n_n          = r_n;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (start) begin
                    n_n   = size_eff;
                    n_row = '0;
                    n_col = '0;
                end
            end
            S_ISSUE: begin
                o_issue.valid = 1'b1;
                o_issue.first = (r_col == '0);
                o_issue.last  = col_last;
                n_col         = col_last ? '0 : r_col + IDX_IN_W'(1);
            end
            S_DRAIN: begin
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit.load = 1'b1;
                    n_row       = r_row + IDX_IN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rd_row = r_row;
    assign o_rd_col = r_col;

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_n     <= SIZE_W'(1);
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_n     <= n_n;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_vector_multiply.sv =====
// Top level of the square matrix times vector block.
`default_nettype none

// Square matrix times vector in signed fixed point (Q8.8 elements, Q24.16
// results). Load transactions (tuser = 0 matrix element at row/col, 1 vector
// element at col) are accepted whenever the block is idle; a write with an index not
// below MAX_SIZE is dropped. A compute transaction (tuser = 2) emits one
// result per row for rows 0 .. n-1, n = size_in_use clamped to 1 .. min(MAX_SIZE, 16),
// with tlast on the final row. Every product goes through one shared multiplier
// that reads one matrix and one vector element a cycle; for each row the block
// reads the n element pairs, waits for the memory read, multiply and sum
// registers to drain, then hands the sum to the output register, which can stall
// on the output side; intake is closed for the whole run.
// Stores are not cleared: read only elements that have been written.
// size_in_use sits at byte address 0 of the register port, reset value 16.
module matrix_vector_multiply
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // row[3:0], col[7:4], value[23:8]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
    // stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // product[39:0], row_index[43:40], zero[47:44]
    output logic             m_axis_tlast,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [SIZE_W-1:0]   r_size;
    logic                r_out_valid;
    logic [PROD_W-1:0]   r_out_product;
    logic [IDX_IN_W-1:0] r_out_row;
    logic                r_out_last;

    t_action             in_action;
    logic [IDX_IN_W-1:0] in_row;
    logic [IDX_IN_W-1:0] in_col;
    logic [VAL_W-1:0]    in_value;
    logic                in_accept;
    logic                row_ok;
    logic                col_ok;
    logic                mat_we;
    logic                vec_we;
    logic                out_free;
    logic                acc_done;
    logic [PROD_W-1:0]   acc;
    logic [VAL_W-1:0]    mat_rdata;
    logic [VAL_W-1:0]    vec_rdata;
    logic [IDX_IN_W-1:0] rd_row;
    logic [IDX_IN_W-1:0] rd_col;
    t_issue              issue;
    t_emit               emit;

    // Unpack the input transaction
    assign in_action = t_action'(s_axis_tuser);
    assign in_row    = s_axis_tdata[3:0];
    assign in_col    = s_axis_tdata[7:4];
    assign in_value  = s_axis_tdata[23:8];
    assign in_accept = s_axis_tvalid & s_axis_tready;

    // Store writes, dropped when the index is outside the store
    assign row_ok = (32'(in_row) < MAX_SIZE);
    assign col_ok = (32'(in_col) < MAX_SIZE);
    assign mat_we = in_accept && (in_action == ACT_MAT_WR) && row_ok && col_ok;
    assign vec_we = in_accept && (in_action == ACT_VEC_WR) && col_ok;

    assign out_free = !r_out_valid || m_axis_tready;

    mvm_store #(
        .MAX_SIZE (MAX_SIZE)
    ) u_store (
        .i_clk       (i_clk),
        .i_mat_we    (mat_we),
        .i_mat_waddr ({IDX_W'(in_row), IDX_W'(in_col)}),
        .i_vec_we    (vec_we),
        .i_vec_waddr (IDX_W'(in_col)),
        .i_wdata     (in_value),
        .i_mat_raddr ({IDX_W'(rd_row), IDX_W'(rd_col)}),
        .i_vec_raddr (IDX_W'(rd_col)),
        .o_mat_rdata (mat_rdata),
        .o_vec_rdata (vec_rdata)
    );

    mvm_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (in_action),
        .i_size     (r_size),
        .i_acc_done (acc_done),
        .i_out_free (out_free),
        .o_in_ready (s_axis_tready),
        .o_issue    (issue),
        .o_rd_row   (rd_row),
        .o_rd_col   (rd_col),
        .o_emit     (emit)
    );

    mvm_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (issue),
        .i_mat_data (mat_rdata),
        .i_vec_data (vec_rdata),
        .o_acc      (acc),
        .o_done     (acc_done)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_product <= acc;
            r_out_row     <= emit.row;
            r_out_last    <= emit.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_row, r_out_product};
    assign m_axis_tlast  = r_out_last;

    // Register port: one register, decoded on the word address bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SIZE)) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIZE) ? {{(32-SIZE_W){1'b0}}, r_size} : '0;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the square matrix times vector block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvm_pkg::*;

    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 4000;

    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    // Register addresses: size_in_use, and a word with no register behind it
    localparam logic [2:0] ADDR_SIZE   = 3'd0;
    localparam logic [2:0] ADDR_NO_REG = 3'd4;

    localparam longint SUM_MAX = (longint'(1) << (PROD_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // One load or compute item as it travels on the input stream
    typedef struct packed {
        logic [1:0]          action;
        logic [IDX_IN_W-1:0] row;
        logic [IDX_IN_W-1:0] col;
        logic [VAL_W-1:0]    value;
    } t_mv_item;

    // One expected element of the result vector
    typedef struct packed {
        logic [PROD_W-1:0]   sum;
        logic [IDX_IN_W-1:0] row_index;
        logic                last;
    } t_row_sum;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // row[3:0], col[7:4], value[23:8]
    logic [1:0]  s_axis_tuser  = '0;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // product[39:0], row_index[43:40], zero[47:44]
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the block state and its size register
    logic signed [VAL_W-1:0] mat_copy [MAX_SIZE_DEF][MAX_SIZE_DEF];
    logic signed [VAL_W-1:0] vec_copy [MAX_SIZE_DEF];
    logic [SIZE_W-1:0]       size_reg = SIZE_RESET;

    // Entries already loaded by queued items; computes only read these
    bit mat_loaded [MAX_SIZE_DEF][MAX_SIZE_DEF];
    bit vec_loaded [MAX_SIZE_DEF];

    t_mv_item items_pending [$];
    t_row_sum sums_awaited  [$];
    t_mv_item next_item;
    t_row_sum sum_due;

    bit feed_taken      = 1'b0;
    bit drain_taken     = 1'b0;
    bit feed_no_gaps    = 1'b0;
    bit drain_no_stalls = 1'b0;
    int feed_wait       = 0;
    int drain_wait      = 0;
    int quiet_cycles    = 0;
    int mismatches      = 0;

    matrix_vector_multiply u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Dimension in use: zero acts as one, anything above the store acts as full size
    function automatic int active_size();
        int n;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
        if (n > OUT_LIMIT) n = OUT_LIMIT;
        return n;
    endfunction

    // Row sums of the stored matrix times the stored vector, saturated to 40 bits
    function automatic void predict_matvec();
        int       n;
        longint   acc;
        t_row_sum rs;
        n = active_size();
        for (int r = 0; r < n; r++) begin
            acc = 0;
            for (int c = 0; c < n; c++) begin
                acc += longint'(mat_copy[r][c]) * longint'(vec_copy[c]);
            end
            if (acc > SUM_MAX) acc = SUM_MAX;
            if (acc < SUM_MIN) acc = SUM_MIN;
            rs.sum       = acc[PROD_W-1:0];
            rs.row_index = r[IDX_IN_W-1:0];
            rs.last      = (r == n - 1);
            sums_awaited.push_back(rs);
        end
    endfunction

    // Element value, biased toward the Q8.8 extremes
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return '1;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Index mostly inside the active window, sometimes anywhere in the store
    function automatic int pick_index(input int n);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, MAX_SIZE_DEF - 1);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic queue_item(input logic [1:0] action, input int row, input int col,
                              input logic [VAL_W-1:0] value);
        t_mv_item it;
        it.action = action;
        it.row    = row[IDX_IN_W-1:0];
        it.col    = col[IDX_IN_W-1:0];
        it.value  = value;
        if (action == ACT_MAT_WR) mat_loaded[it.row][it.col] = 1'b1;
        if (action == ACT_VEC_WR) vec_loaded[it.col] = 1'b1;
        items_pending.push_back(it);
    endtask

    // Load every entry of the n x n window and of vector entries 0 .. n-1 not written yet
    task automatic fill_unwritten(input int n);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (!mat_loaded[r][c]) queue_item(ACT_MAT_WR, r, c, pick_value());
            end
        end
        for (int c = 0; c < n; c++) begin
            if (!vec_loaded[c]) queue_item(ACT_VEC_WR, $urandom_range(0, 15), c, pick_value());
        end
    endtask

    // Mix of loads, computes and ignored codes; window is fully loaded beforehand
    task automatic random_items(input int count);
        int n;
        int pick;
        n = active_size();
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_item(ACT_MAT_WR, pick_index(n), pick_index(n), pick_value());
            else if (pick < 68)
                queue_item(ACT_VEC_WR, $urandom_range(0, 15), pick_index(n), pick_value());
            else if (pick < 90)
                queue_item(ACT_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                           VAL_W'($urandom()));
            else
                queue_item(ACT_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                           VAL_W'($urandom()));
        end
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SIZE) size_reg = data[SIZE_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper data bits are random; only the low five bits hold the size
    task automatic set_size(input logic [SIZE_W-1:0] n);
        write_reg(ADDR_SIZE, ($urandom() & ~32'h1F) | 32'(n));
    endtask

    // Block idle: everything sent, every result back, pipeline settled
    task automatic wait_quiet();
        while (items_pending.size() != 0 || s_axis_tvalid || sums_awaited.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] n, input int count);
        feed_no_gaps    = ($urandom_range(0, 3) == 0);
        drain_no_stalls = ($urandom_range(0, 3) == 0);
        set_size(n);
        fill_unwritten(active_size());
        random_items(count);
        wait_quiet();
    endtask

    // Input driver: one item per transaction, random gap after each
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (feed_taken) feed_wait = feed_no_gaps ? 0 : $urandom_range(0, GAP_MAX);
            if (s_axis_tvalid && !feed_taken) begin
                // hold until the block takes it
            end else if (feed_wait > 0) begin
                feed_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (items_pending.size() != 0) begin
                next_item = items_pending.pop_front();
                s_axis_tuser  <= next_item.action;
                s_axis_tdata  <= {next_item.value, next_item.col, next_item.row};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stall after each result transaction
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (drain_taken) drain_wait = drain_no_stalls ? 0 : $urandom_range(0, GAP_MAX);
            if (drain_wait > 0) begin
                drain_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: update the local state, predict, and check results
    always @(posedge i_clk) begin
        feed_taken  = i_rst_n && s_axis_tvalid && s_axis_tready;
        drain_taken = i_rst_n && m_axis_tvalid && m_axis_tready;

        if (feed_taken) begin
            case (s_axis_tuser)
                ACT_MAT_WR:  mat_copy[s_axis_tdata[3:0]][s_axis_tdata[7:4]] = s_axis_tdata[23:8];
                ACT_VEC_WR:  vec_copy[s_axis_tdata[7:4]] = s_axis_tdata[23:8];
                ACT_COMPUTE: predict_matvec();
                default: ;
            endcase
        end

        if (drain_taken) begin
            if (sums_awaited.size() == 0) begin
                $error("result with none expected: product %0d row_index %0d",
                       $signed(m_axis_tdata[PROD_W-1:0]),
                       m_axis_tdata[PROD_W+IDX_IN_W-1:PROD_W]);
                mismatches++;
            end else begin
                sum_due = sums_awaited.pop_front();
                if (m_axis_tdata[PROD_W-1:0] !== sum_due.sum) begin
                    $error("product: expected %0d, got %0d", $signed(sum_due.sum),
                           $signed(m_axis_tdata[PROD_W-1:0]));
                    mismatches++;
                end
                if (m_axis_tdata[PROD_W+IDX_IN_W-1:PROD_W] !== sum_due.row_index) begin
                    $error("row_index: expected %0d, got %0d", sum_due.row_index,
                           m_axis_tdata[PROD_W+IDX_IN_W-1:PROD_W]);
                    mismatches++;
                end
                if (m_axis_tlast !== sum_due.last) begin
                    $error("last: expected %0b, got %0b", sum_due.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end

        // Watchdog on stretches with no transaction on either stream
        if (feed_taken || drain_taken) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-element window with extreme values
        set_size(5'd1);
        queue_item(ACT_MAT_WR, 0, 0, 16'h8000);
        queue_item(ACT_VEC_WR, 0, 0, 16'h8000);
        queue_item(ACT_COMPUTE, 0, 0, 16'h0000);
        queue_item(ACT_MAT_WR, 0, 0, 16'h7FFF);
        queue_item(ACT_COMPUTE, 0, 0, 16'h0000);
        queue_item(ACT_VEC_WR, 15, 0, 16'h7FFF);
        queue_item(ACT_COMPUTE, 15, 15, 16'hFFFF);
        // unused code, then loads at the far corner outside the window
        queue_item(ACT_UNUSED, 15, 15, 16'hFFFF);
        queue_item(ACT_MAT_WR, 15, 15, 16'hFFFF);
        queue_item(ACT_VEC_WR, 15, 15, 16'h0001);
        queue_item(ACT_MAT_WR, 0, 0, 16'hFFFF);
        queue_item(ACT_COMPUTE, 0, 0, 16'h0000);
        wait_quiet();

        // Size zero behaves as one
        set_size(5'd0);
        queue_item(ACT_COMPUTE, 0, 0, 16'h0000);
        wait_quiet();

        // Write to an address with no register: size must not change
        write_reg(ADDR_NO_REG, 32'h0000_0002);
        queue_item(ACT_COMPUTE, 0, 0, 16'h0000);
        wait_quiet();

        // Random phases over several sizes; loads of new window entries come first
        run_phase(5'd3, 10);
        run_phase(5'd1, 10);
        run_phase(5'd7, 10);
        run_phase(5'd2, 10);
        run_phase(5'd12, 10);
        run_phase(SIZE_W'($urandom_range(1, 12)), 10);
        run_phase(5'd0, 10);
        run_phase(5'd5, 10);

        if (mismatches == 0 && sums_awaited.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
